// ===== hw/rtl/fba_pkg.sv =====
// Shared types, codes and helpers for the frame bitmap allocator.
package fba_pkg;

    localparam int NUM_FRAMES_DEF = 4096;
    localparam int WORD_BITS      = 32;
    localparam int BIT_AW         = 5;
    localparam int FRAME_FIELD_W  = 12;
    localparam int STATUS_W       = 3;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 3'd0,
        ST_HAD_FRAME = 3'd1,
        ST_NO_FRAME  = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOTHING   = 3'd4
    } t_status;

    function automatic logic [BIT_AW-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_AW-1:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word[b]) begin
                idx = BIT_AW'(b);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/fba_if.sv =====
// Request and response channel interfaces of the frame bitmap allocator.
interface fba_req_if
    import fba_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [FRAME_FIELD_W-1:0] current_frame;
    logic                     supervisor;
    logic                     writable;

    modport source (output valid, command, current_frame, supervisor, writable,
                    input ready);
    modport sink   (input valid, command, current_frame, supervisor, writable,
                    output ready);
endinterface

interface fba_rsp_if
    import fba_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [FRAME_FIELD_W-1:0] frame_index;
    logic                     present_bit;
    logic                     rw_bit;
    logic                     user_bit;

    modport source (output valid, status, frame_index, present_bit, rw_bit, user_bit,
                    input ready);
    modport sink   (input valid, status, frame_index, present_bit, rw_bit, user_bit,
                    output ready);
endinterface

// ===== hw/rtl/frame_bitmap_allocator.sv =====
// Top level of the first-fit bitmap page frame allocator.
//
// Request channel i_req carries command, current_frame, supervisor and
// writable; response channel o_rsp returns one beat per request with
// status, frame_index and the present, rw and user page flags.
// A request is taken only while the block is idle; ready then drops until
// the response is loaded into the output register.
// Allocate of an entry that already holds a frame, free of frame 0 and free
// beyond NUM_FRAMES answer without touching the bitmap. A free reads the
// bitmap word, then writes it back. An allocate scans the bitmap one 32-bit
// word per cycle from word 0 through the single memory read port, up to the
// first word with a clear bit or the last word.
// After reset the block clears every bitmap word, one word per cycle, with
// ready low.
// A stalled receiver holds the response in the output register; the next
// request is still accepted, and its response waits until the register frees.
module frame_bitmap_allocator
    import fba_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fba_req_if.sink     i_req,
    fba_rsp_if.source   o_rsp
);

    localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FW    = AW + BIT_AW;
    localparam logic [AW-1:0] LAST_WORD   = AW'(WORDS - 1);
    localparam logic [FW:0]   FRAME_LIMIT = (FW + 1)'(NUM_FRAMES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [AW-1:0]            r_clr_addr;
    logic [AW-1:0]            r_scan_addr;
    logic [AW-1:0]            r_chk_addr;
    logic                     r_chk_vld;
    logic [AW-1:0]            r_word;
    logic [BIT_AW-1:0]        r_bit;
    logic [WORD_BITS-1:0]     r_bitword;
    t_status                  r_res_status;
    logic [FRAME_FIELD_W-1:0] r_res_idx;
    logic                     r_res_pres;
    logic                     r_res_rw;
    logic                     r_res_usr;
    logic                     r_out_vld;
    t_status                  r_out_status;
    logic [FRAME_FIELD_W-1:0] r_out_idx;
    logic                     r_out_pres;
    logic                     r_out_rw;
    logic                     r_out_usr;

    logic                     s_req_fire;
    logic                     s_load;
    logic                     s_we;
    logic [AW-1:0]            s_waddr;
    logic [WORD_BITS-1:0]     s_wdata;
    logic [AW-1:0]            s_raddr;
    logic [WORD_BITS-1:0]     s_rdata;
    logic [BIT_AW-1:0]        s_low;
    logic [FW-1:0]            s_frame;
    logic                     s_cur_in_range;

    fba_bitmap_ram #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    assign i_req.ready    = (r_state == S_IDLE);
    assign s_req_fire     = i_req.valid && i_req.ready;
    assign s_load         = (r_state == S_DONE) && (!r_out_vld || o_rsp.ready);
    assign s_raddr        = (r_state == S_SCAN) ? r_scan_addr : r_word;
    assign s_low          = lowest_zero(s_rdata);
    assign s_frame        = {r_chk_addr, s_low};
    assign s_cur_in_range = 32'(i_req.current_frame) < NUM_FRAMES;

    always_comb begin
        s_we    = 1'b0;
        s_waddr = r_word;
        s_wdata = r_bitword;
        unique case (r_state)
            S_CLEAR: begin
                s_we    = 1'b1;
                s_waddr = r_clr_addr;
                s_wdata = '0;
            end
            S_ALLOC: begin
                s_we = 1'b1;
            end
            S_FREE_WR: begin
                s_we    = 1'b1;
                s_wdata = s_rdata & ~(WORD_BITS'(1) << r_bit);
            end
            default: begin
                s_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_scan_addr  <= '0;
            r_chk_addr   <= '0;
            r_chk_vld    <= 1'b0;
            r_word       <= '0;
            r_bit        <= '0;
            r_bitword    <= '0;
            r_res_status <= ST_NOTHING;
            r_res_idx    <= '0;
            r_res_pres   <= 1'b0;
            r_res_rw     <= 1'b0;
            r_res_usr    <= 1'b0;
            r_out_vld    <= 1'b0;
            r_out_status <= ST_NOTHING;
            r_out_idx    <= '0;
            r_out_pres   <= 1'b0;
            r_out_rw     <= 1'b0;
            r_out_usr    <= 1'b0;
        end else begin
            if (s_load) begin
                r_out_vld    <= 1'b1;
                r_out_status <= r_res_status;
                r_out_idx    <= r_res_idx;
                r_out_pres   <= r_res_pres;
                r_out_rw     <= r_res_rw;
                r_out_usr    <= r_res_usr;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_req_fire) begin
                        r_res_idx   <= '0;
                        r_res_pres  <= 1'b0;
                        r_res_rw    <= i_req.writable;
                        r_res_usr   <= !i_req.supervisor;
                        r_word      <= AW'(i_req.current_frame >> BIT_AW);
                        r_bit       <= i_req.current_frame[BIT_AW-1:0];
                        r_scan_addr <= '0;
                        r_chk_vld   <= 1'b0;
                        priority if (i_req.command == CMD_ALLOC &&
                                     i_req.current_frame != '0) begin
                            r_res_status <= ST_HAD_FRAME;
                            r_res_idx    <= i_req.current_frame;
                            r_res_rw     <= 1'b0;
                            r_res_usr    <= 1'b0;
                            r_state      <= S_DONE;
                        end else if (i_req.command == CMD_ALLOC) begin
                            r_state <= S_SCAN;
                        end else if (i_req.current_frame == '0) begin
                            r_res_status <= ST_NOTHING;
                            r_res_rw     <= 1'b0;
                            r_res_usr    <= 1'b0;
                            r_state      <= S_DONE;
                        end else begin
                            r_res_status <= ST_FREED;
                            r_res_rw     <= 1'b0;
                            r_res_usr    <= 1'b0;
                            r_state      <= s_cur_in_range ? S_FREE_RD : S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_chk_vld  <= 1'b1;
                    r_chk_addr <= r_scan_addr;
                    if (r_scan_addr != LAST_WORD) begin
                        r_scan_addr <= r_scan_addr + AW'(1);
                    end
                    if (r_chk_vld) begin
                        priority if (s_rdata != '1 && {1'b0, s_frame} < FRAME_LIMIT) begin
                            r_res_status <= ST_ALLOCATED;
                            r_res_idx    <= FRAME_FIELD_W'(s_frame);
                            r_res_pres   <= 1'b1;
                            r_word       <= r_chk_addr;
                            r_bitword    <= s_rdata | (WORD_BITS'(1) << s_low);
                            r_state      <= S_ALLOC;
                        end else if (s_rdata != '1 || r_chk_addr == LAST_WORD) begin
                            r_res_status <= ST_NO_FRAME;
                            r_res_rw     <= 1'b0;
                            r_res_usr    <= 1'b0;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_ALLOC: begin
                    r_state <= S_DONE;
                end
                S_FREE_RD: begin
                    r_state <= S_FREE_WR;
                end
                S_FREE_WR: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (s_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.frame_index = r_out_idx;
    assign o_rsp.present_bit = r_out_pres;
    assign o_rsp.rw_bit      = r_out_rw;
    assign o_rsp.user_bit    = r_out_usr;

`ifndef NO_ASSERTIONS
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_req_fire |=> !i_req.ready)
        else $error("request taken while a previous one is in work");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> r_chk_addr <= LAST_WORD)
        else $error("scan ran past the last bitmap word");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_vld && !o_rsp.ready) |=> r_state == S_DONE)
        else $error("result left done state while output register was full");

    a_alloc_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_load |=> (o_rsp.present_bit == (o_rsp.status == ST_ALLOCATED)))
        else $error("present flag does not match allocation status");
`endif

endmodule

// ===== hw/rtl/fba_bitmap_ram.sv =====
// Bitmap word memory: one write port, one read port with registered data.
module fba_bitmap_ram
    import fba_pkg::*;
#(
    parameter int DEPTH = NUM_FRAMES_DEF / WORD_BITS,
    parameter int AW    = 7
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic [AW-1:0]        i_raddr,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
